// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the lexer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/scl_pkg.sv -----
// ---------------------------------------------------------------------------
// scl_pkg
// Types, token codes and character classes for the script token lexer.
// ---------------------------------------------------------------------------
package scl_pkg;

	localparam int MAX_RES    = 4;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef logic [4:0] kind_t;
	localparam kind_t K_EOF     = 5'd0;
	localparam kind_t K_EOL     = 5'd1;
	localparam kind_t K_SPACE   = 5'd2;
	localparam kind_t K_NUM     = 5'd3;
	localparam kind_t K_WORD    = 5'd4;
	localparam kind_t K_BOOL    = 5'd5;
	localparam kind_t K_STRING  = 5'd6;
	localparam kind_t K_ADD     = 5'd7;
	localparam kind_t K_SUB     = 5'd8;
	localparam kind_t K_MUL     = 5'd9;
	localparam kind_t K_COMMENT = 5'd10;
	localparam kind_t K_DIV     = 5'd11;
	localparam kind_t K_ASSIGN  = 5'd12;
	localparam kind_t K_LBRACE  = 5'd13;
	localparam kind_t K_RBRACE  = 5'd14;
	localparam kind_t K_LPAREN  = 5'd15;
	localparam kind_t K_RPAREN  = 5'd16;
	localparam kind_t K_COMMA   = 5'd17;
	localparam kind_t K_ERR     = 5'd18;

	typedef logic [1:0] err_t;
	localparam err_t E_NONE        = 2'd0;
	localparam err_t E_NUM_PERIOD  = 2'd1;
	localparam err_t E_OPEN_STRING = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SPACE,
		MODE_NUM,
		MODE_WORD,
		MODE_STRING
	} lex_mode_t;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam logic [7:0] TRUE_TEXT  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
	localparam logic [7:0] FALSE_TEXT [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic        is_value;
		logic [7:0]  value_byte;
		kind_t       token_kind;
		logic [15:0] line_number;
		err_t        error_code;
		logic        last;
	} out_t;

	// Up to MAX_RES results produced by one item.
	typedef struct packed {
		logic [2:0]               count;
		out_t [MAX_RES-1:0]       res;
	} burst_t;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
	endfunction

	function automatic logic is_word_char(logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
	endfunction

	// Single-character operator or bracket; K_ERR when b is none of them.
	function automatic kind_t op_kind(logic [7:0] b);
		kind_t k;
		unique case (b)
			8'h2B:   k = K_ADD;
			8'h2D:   k = K_SUB;
			8'h2A:   k = K_MUL;
			8'h3D:   k = K_ASSIGN;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h2C:   k = K_COMMA;
			default: k = K_ERR;
		endcase
		return k;
	endfunction

	// bit0: still matches "true", bit1: still matches "false"
	function automatic logic [1:0] bool_flags_next(logic [2:0] p, logic [1:0] f,
			logic [7:0] b);
		logic [1:0] nf;
		nf = f;
		if (!((p < 3'd4) && (b == TRUE_TEXT[p[1:0]])))
			nf[0] = 1'b0;
		if (!((p < 3'd5) && (b == ((p < 3'd5) ? FALSE_TEXT[p] : 8'h00))))
			nf[1] = 1'b0;
		return nf;
	endfunction

	function automatic kind_t word_kind(logic [2:0] len, logic [1:0] f);
		return ((f[0] && (len == 3'd4)) || (f[1] && (len == 3'd5))) ? K_BOOL : K_WORD;
	endfunction

	function automatic out_t mk_res(logic isval, logic [7:0] b, kind_t k, err_t e,
			logic [15:0] line);
		out_t r;
		r.is_value    = isval;
		r.value_byte  = b;
		r.token_kind  = k;
		r.line_number = line;
		r.error_code  = e;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

// ----- hdl/script_token_lexer_top.sv -----
// ---------------------------------------------------------------------------
// script_token_lexer_top
// Streaming tokenizer for a small script language, one source byte per item.
// ---------------------------------------------------------------------------
// Input channel (char_*): one source byte, or an end-of-input mark, per
// transaction. Output channel (tok_*): one result per transaction, either a
// value byte of the token being built or a token close carrying kind, line
// number and error code; 'last' flags the final result of each input item.
// An input item lands in an input register, is lexed combinationally and its
// zero to four results are written to an 8-entry result queue that feeds a
// registered output, so a result passes the input register, the queue and the
// output register in that order. An item leaves the input register whenever
// the queue has room for four results, so one byte per cycle is sustained
// while the output is taken at the same rate; bytes with several results take
// one output transaction per result and the queue absorbs short bursts.
// char_stall rises only while the input register holds an item the queue
// cannot yet take; tok_stall holds the output register and backs up the queue.
// Reset (arst_n low) empties all stages, sets the line count to one and idles
// the lexer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module script_token_lexer_top import scl_pkg::*; #(
	parameter int LINE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	output logic char_stall,
	input  in_t  char_data,
	output logic tok_valid,
	input  logic tok_stall,
	output out_t tok_data
);

	logic             valid_s1;
	in_t              item_s1;
	logic             adv;
	burst_t           burst;

	out_t             fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic             load_out, pop;
	logic [FIFO_AW:0]   add_cnt;

	logic             tok_valid_q;
	out_t             tok_data_q;

	// item in the input register moves on when the queue has room for a full burst
	assign adv        = valid_s1 && (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
	assign char_stall = valid_s1 && !adv;
	assign load_out   = !tok_valid_q || !tok_stall;
	assign pop        = load_out && (cnt_q != '0);
	assign add_cnt    = adv ? (FIFO_AW+1)'(burst.count) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!char_stall)
			valid_s1 <= char_valid;
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall)
			item_s1 <= char_data;
	end

	scl_core #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.burst  (burst)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) < burst.count)
					fifo_mem[wr_ptr_q + FIFO_AW'(i)] <= burst.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(burst.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + add_cnt - (pop ? (FIFO_AW+1)'(1) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_valid_q <= 1'b0;
		else if (load_out)
			tok_valid_q <= (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (pop)
			tok_data_q <= fifo_mem[rd_ptr_q];
	end

	assign tok_valid = tok_valid_q;
	assign tok_data  = tok_data_q;

	`CHK_ALWAYS(a_fifo_bound, clk, arst_n, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
	`CHK_ALWAYS(a_burst_size, clk, arst_n, !adv || burst.count <= 3'(MAX_RES), "burst larger than four results")
	`CHK_NEXT(a_pop_loads, clk, arst_n, pop, tok_valid_q, "queue pop did not load output register")

endmodule

// ----- hdl/scl_core.sv -----
// ---------------------------------------------------------------------------
// scl_core
// Lexer state and single-pass token logic: one item in, up to four results out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scl_core import scl_pkg::*; #(
	parameter int LINE_WIDTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   fire,
	input  in_t    item,
	output burst_t burst
);

	lex_mode_t             mode_q, mode_n;
	logic [7:0]            held_byte_q, held_byte_n;
	logic                  held_q, held_n;
	logic [LINE_WIDTH-1:0] line_q;
	logic                  line_inc;
	logic [2:0]            wlen_q, wlen_n;
	logic [1:0]            flags_q, flags_n;

	logic [31:0] line_ext;
	logic [15:0] line16;
	logic [7:0]  b;
	logic        do_start;
	logic [2:0]  n;
	out_t        res [MAX_RES];

	assign line_ext = 32'(line_q);
	assign line16   = (line_ext > 32'h0000_FFFF) ? 16'hFFFF : line_ext[15:0];
	assign b        = item.in_byte;

	always_comb begin
		mode_n      = mode_q;
		held_byte_n = held_byte_q;
		held_n      = held_q;
		wlen_n      = wlen_q;
		flags_n     = flags_q;
		line_inc    = 1'b0;
		do_start    = 1'b0;
		n           = 3'd0;
		for (int i = 0; i < MAX_RES; i++)
			res[i] = '0;

		if (item.end_of_input) begin
			held_n = 1'b0;
			if (held_q) begin
				if (mode_q == MODE_NUM) begin
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_NUM_PERIOD, line16);
					n = n + 3'd1;
				end else if (held_byte_q == CH_PERIOD) begin
					res[n[1:0]] = mk_res(1'b1, CH_PERIOD, K_ERR, E_NONE, line16);
					n = n + 3'd1;
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_NONE, line16);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_DIV, E_NONE, line16);
					n = n + 3'd1;
				end
			end else begin
				unique case (mode_q)
					MODE_SPACE: begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_SPACE, E_NONE, line16);
						n = n + 3'd1;
					end
					MODE_NUM: begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_NUM, E_NONE, line16);
						n = n + 3'd1;
					end
					MODE_WORD: begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, word_kind(wlen_q, flags_q), E_NONE,
							line16);
						n = n + 3'd1;
					end
					MODE_STRING: begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_OPEN_STRING, line16);
						n = n + 3'd1;
					end
					default: ;
				endcase
			end
			mode_n = MODE_IDLE;
			res[n[1:0]] = mk_res(1'b0, 8'h00, K_EOF, E_NONE, line16);
			n = n + 3'd1;
		end else if (held_q) begin
			// one-byte lookahead on a held period or slash
			held_n = 1'b0;
			if (mode_q == MODE_NUM) begin
				if (is_digit(b)) begin
					res[n[1:0]] = mk_res(1'b1, CH_PERIOD, K_NUM, E_NONE, line16);
					n = n + 3'd1;
					res[n[1:0]] = mk_res(1'b1, b, K_NUM, E_NONE, line16);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_NUM_PERIOD, line16);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end else if (held_byte_q == CH_PERIOD) begin
				mode_n = MODE_IDLE;
				if (is_digit(b)) begin
					mode_n = MODE_NUM;
					res[n[1:0]] = mk_res(1'b1, CH_PERIOD, K_NUM, E_NONE, line16);
					n = n + 3'd1;
					res[n[1:0]] = mk_res(1'b1, b, K_NUM, E_NONE, line16);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk_res(1'b1, CH_PERIOD, K_ERR, E_NONE, line16);
					n = n + 3'd1;
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_NONE, line16);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end else begin
				mode_n = MODE_IDLE;
				if (b == CH_SLASH) begin
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_COMMENT, E_NONE, line16);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = mk_res(1'b0, 8'h00, K_DIV, E_NONE, line16);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end
		end else begin
			unique case (mode_q)
				MODE_SPACE: begin
					if (!is_space(b)) begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_SPACE, E_NONE, line16);
						n = n + 3'd1;
						do_start = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(b)) begin
						res[n[1:0]] = mk_res(1'b1, b, K_NUM, E_NONE, line16);
						n = n + 3'd1;
					end else if (b == CH_PERIOD) begin
						held_byte_n = b;
						held_n      = 1'b1;
					end else begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_NUM, E_NONE, line16);
						n = n + 3'd1;
						do_start = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_word_char(b)) begin
						flags_n = bool_flags_next(wlen_q, flags_q, b);
						wlen_n  = (wlen_q < 3'd7) ? wlen_q + 3'd1 : wlen_q;
						res[n[1:0]] = mk_res(1'b1, b, K_WORD, E_NONE, line16);
						n = n + 3'd1;
					end else begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, word_kind(wlen_q, flags_q), E_NONE,
							line16);
						n = n + 3'd1;
						do_start = 1'b1;
					end
				end
				MODE_STRING: begin
					if (b == CH_QUOTE) begin
						res[n[1:0]] = mk_res(1'b0, 8'h00, K_STRING, E_NONE, line16);
						n = n + 3'd1;
						mode_n = MODE_IDLE;
					end else begin
						res[n[1:0]] = mk_res(1'b1, b, K_STRING, E_NONE, line16);
						n = n + 3'd1;
					end
				end
				default: do_start = 1'b1;
			endcase
		end

		// fresh token start, always the final action of a step
		if (do_start) begin
			mode_n = MODE_IDLE;
			priority if (b == CH_NL) begin
				res[n[1:0]] = mk_res(1'b0, 8'h00, K_EOL, E_NONE, line16);
				n = n + 3'd1;
				line_inc = 1'b1;
			end else if (b == CH_SEMI) begin
				res[n[1:0]] = mk_res(1'b0, 8'h00, K_EOL, E_NONE, line16);
				n = n + 3'd1;
			end else if (is_space(b)) begin
				mode_n = MODE_SPACE;
			end else if (is_digit(b)) begin
				mode_n = MODE_NUM;
				res[n[1:0]] = mk_res(1'b1, b, K_NUM, E_NONE, line16);
				n = n + 3'd1;
			end else if ((b == CH_PERIOD) || (b == CH_SLASH)) begin
				held_byte_n = b;
				held_n      = 1'b1;
			end else if (is_alpha(b) || (b == CH_UNDER)) begin
				mode_n  = MODE_WORD;
				flags_n = bool_flags_next(3'd0, 2'b11, b);
				wlen_n  = 3'd1;
				res[n[1:0]] = mk_res(1'b1, b, K_WORD, E_NONE, line16);
				n = n + 3'd1;
			end else if (b == CH_QUOTE) begin
				mode_n = MODE_STRING;
			end else if (op_kind(b) != K_ERR) begin
				res[n[1:0]] = mk_res(1'b0, 8'h00, op_kind(b), E_NONE, line16);
				n = n + 3'd1;
			end else begin
				res[n[1:0]] = mk_res(1'b1, b, K_ERR, E_NONE, line16);
				n = n + 3'd1;
				res[n[1:0]] = mk_res(1'b0, 8'h00, K_ERR, E_NONE, line16);
				n = n + 3'd1;
			end
		end

		if (n != 3'd0)
			res[2'(n - 3'd1)].last = 1'b1;

		burst.count = n;
		for (int i = 0; i < MAX_RES; i++)
			burst.res[i] = res[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			held_byte_q <= '0;
			held_q      <= 1'b0;
			line_q      <= LINE_WIDTH'(1);
			wlen_q      <= '0;
			flags_q     <= 2'b11;
		end else if (fire) begin
			mode_q      <= mode_n;
			held_byte_q <= held_byte_n;
			held_q      <= held_n;
			wlen_q      <= wlen_n;
			flags_q     <= flags_n;
			if (line_inc && (line_q != '1))
				line_q <= line_q + LINE_WIDTH'(1);
		end
	end

	`CHK_ALWAYS(a_held_mode, clk, arst_n, !held_q || mode_q == MODE_IDLE || mode_q == MODE_NUM, "held byte outside idle or number mode")
	`CHK_ALWAYS(a_line_nonzero, clk, arst_n, line_q != '0, "line counter wrapped to zero")
	`CHK_NEXT(a_eoi_clears, clk, arst_n, fire && item.end_of_input, !held_q && mode_q == MODE_IDLE, "end of input left lexer busy")

endmodule
